/* rtl/nms_pkg.sv */
`default_nettype none

package nms_pkg;

   localparam int DIM_CFG_W  = 12;
   localparam int THR_W      = 16;
   localparam int CSR_DATA_W = 16;
   localparam int CSR_IDX_W  = 2;
   localparam int ROW_W      = 12;
   localparam int POS_W      = 11;
   localparam int MAX_HEIGHT = 2048;

   localparam logic [CSR_IDX_W-1:0] CSR_IMAGE_WIDTH  = CSR_IDX_W'(0);
   localparam logic [CSR_IDX_W-1:0] CSR_IMAGE_HEIGHT = CSR_IDX_W'(1);
   localparam logic [CSR_IDX_W-1:0] CSR_MIN_RESPONSE = CSR_IDX_W'(2);

   localparam logic [DIM_CFG_W-1:0] IMAGE_WIDTH_RESET  = DIM_CFG_W'(640);
   localparam logic [DIM_CFG_W-1:0] IMAGE_HEIGHT_RESET = DIM_CFG_W'(480);
   localparam logic [THR_W-1:0]     MIN_RESPONSE_RESET = THR_W'(51);

   typedef struct packed {
      logic             emit;
      logic             interior;
      logic             frame_end;
      logic [POS_W-1:0] row;
      logic [POS_W-1:0] column;
   } pos_info_type;

endpackage

`default_nettype wire

/* rtl/nms_stream_if.sv */
`default_nettype none

interface nms_req_if #(
   parameter int PIXEL_BITS = 16
);
   logic                  valid;
   logic                  ready;
   logic [PIXEL_BITS-1:0] response;
   logic                  padding;

   modport source (output valid, output response, output padding, input ready);
   modport sink (input valid, input response, input padding, output ready);
endinterface

interface nms_rsp_if
   import nms_pkg::*;
#(
   parameter int PIXEL_BITS = 16
);
   logic                  valid;
   logic                  ready;
   logic [PIXEL_BITS-1:0] kept_value;
   logic [POS_W-1:0]      row;
   logic [POS_W-1:0]      column;
   logic                  frame_end;

   modport source (output valid, output kept_value, output row, output column,
                   output frame_end, input ready);
   modport sink (input valid, input kept_value, input row, input column,
                 input frame_end, output ready);
endinterface

`default_nettype wire

/* rtl/window_nonmax_suppress_threshold.sv */
// 3x3 non-maximum suppression with threshold over a raster pixel stream.
// The line store is read as a pixel is accepted, and a result is registered as the pixel that
// completes its window leaves the pixel stage, image_width+1 transfers after the centre pixel.
// Throughput: one pixel per clock; a stalled result holds the pixel stage and the input.
// Reset (synchronous): configuration registers return to their defaults, position counters
// and valids clear; line store contents are left as they are.
`default_nettype none

module window_nonmax_suppress_threshold
   import nms_pkg::*;
#(
   parameter int MAX_WIDTH  = 2048,
   parameter int PIXEL_BITS = 16
) (
   input  wire logic                  clock,
   input  wire logic                  reset,
   nms_req_if.sink                    req_chan,
   nms_rsp_if.source                  rsp_chan,
   input  wire logic                  csr_we,
   input  wire logic [CSR_IDX_W-1:0]  csr_index,
   input  wire logic [CSR_DATA_W-1:0] csr_wdata
);

   localparam int ADDR_W = $clog2(MAX_WIDTH);
   localparam int CMP_W  = (PIXEL_BITS > THR_W) ? PIXEL_BITS : THR_W;

   logic [DIM_CFG_W-1:0] width_ff, height_ff;
   logic [THR_W-1:0]     thr_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         width_ff  <= IMAGE_WIDTH_RESET;
         height_ff <= IMAGE_HEIGHT_RESET;
         thr_ff    <= MIN_RESPONSE_RESET;
      end else if (csr_we) begin
         unique case (csr_index)
            CSR_IMAGE_WIDTH:  width_ff  <= DIM_CFG_W'(csr_wdata);
            CSR_IMAGE_HEIGHT: height_ff <= DIM_CFG_W'(csr_wdata);
            CSR_MIN_RESPONSE: thr_ff    <= THR_W'(csr_wdata);
            default: ;
         endcase
      end
   end

   logic                  accept, s1_fire, advance;
   pos_info_type          pos;
   logic [ADDR_W-1:0]     slot;

   logic                  s1_valid_ff;
   pos_info_type          s1_pos_ff;
   logic [PIXEL_BITS-1:0] s1_x_ff;
   logic [ADDR_W-1:0]     s1_slot_ff;
   logic                  s1_fwd_ff;
   logic [ADDR_W-1:0]     prev_slot_ff;
   logic                  prev_ok_ff;

   logic [PIXEL_BITS-1:0] last_mid_ff, last_x_ff;
   logic [PIXEL_BITS-1:0] win_ff [3][2];

   logic [2*PIXEL_BITS-1:0] rd_data;
   logic [PIXEL_BITS-1:0]   new_col [3];
   logic [PIXEL_BITS-1:0]   center, kept_in;
   logic                    larger, keep;

   logic                  out_valid_ff;
   logic [PIXEL_BITS-1:0] out_value_ff;
   logic [POS_W-1:0]      out_row_ff, out_col_ff;
   logic                  out_fend_ff;

   assign advance        = !out_valid_ff || rsp_chan.ready;
   assign s1_fire        = s1_valid_ff && (!s1_pos_ff.emit || advance);
   assign req_chan.ready = !s1_valid_ff || s1_fire;
   assign accept         = req_chan.valid && req_chan.ready;

   nms_pos #(
      .MAX_WIDTH (MAX_WIDTH)
   ) u_pos (
      .clock        (clock),
      .reset        (reset),
      .advance      (accept),
      .image_width  (width_ff),
      .image_height (height_ff),
      .pos          (pos),
      .slot         (slot)
   );

   // upper row in the high half, middle row in the low half
   nms_ram #(
      .WIDTH (2 * PIXEL_BITS),
      .DEPTH (MAX_WIDTH)
   ) u_lines (
      .clock   (clock),
      .wr_en   (s1_fire),
      .wr_addr (s1_slot_ff),
      .wr_data ({new_col[1], new_col[2]}),
      .rd_en   (accept),
      .rd_addr (slot),
      .rd_data (rd_data)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
         prev_ok_ff  <= 1'b0;
      end else begin
         if (accept) begin
            s1_valid_ff <= 1'b1;
            prev_ok_ff  <= 1'b1;
         end else if (s1_fire) begin
            s1_valid_ff <= 1'b0;
         end
      end
   end

   // a slot read right after the same slot bypasses the line store
   always_ff @(posedge clock) begin
      if (accept) begin
         s1_pos_ff    <= pos;
         s1_x_ff      <= req_chan.padding ? '0 : req_chan.response;
         s1_slot_ff   <= slot;
         s1_fwd_ff    <= prev_ok_ff && slot == prev_slot_ff;
         prev_slot_ff <= slot;
      end
   end

   always_comb begin
      new_col[0] = s1_fwd_ff ? last_mid_ff : rd_data[2*PIXEL_BITS-1:PIXEL_BITS];
      new_col[1] = s1_fwd_ff ? last_x_ff : rd_data[PIXEL_BITS-1:0];
      new_col[2] = s1_x_ff;
      center     = win_ff[1][1];
      larger     = 1'b0;
      for (int r = 0; r < 3; r++) begin
         larger = larger || win_ff[r][0] > center || win_ff[r][1] > center
                  || new_col[r] > center;
      end
      keep    = CMP_W'(center) >= CMP_W'(thr_ff) && !larger;
      kept_in = (s1_pos_ff.interior && !keep) ? '0 : center;
   end

   always_ff @(posedge clock) begin
      if (s1_fire) begin
         last_mid_ff <= new_col[1];
         last_x_ff   <= new_col[2];
         for (int r = 0; r < 3; r++) begin
            win_ff[r][0] <= win_ff[r][1];
            win_ff[r][1] <= new_col[r];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else if (s1_fire && s1_pos_ff.emit) begin
         out_valid_ff <= 1'b1;
      end else if (rsp_chan.ready) begin
         out_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (s1_fire && s1_pos_ff.emit) begin
         out_value_ff <= kept_in;
         out_row_ff   <= s1_pos_ff.row;
         out_col_ff   <= s1_pos_ff.column;
         out_fend_ff  <= s1_pos_ff.frame_end;
      end
   end

   assign rsp_chan.valid      = out_valid_ff;
   assign rsp_chan.kept_value = out_value_ff;
   assign rsp_chan.row        = out_row_ff;
   assign rsp_chan.column     = out_col_ff;
   assign rsp_chan.frame_end  = out_fend_ff;

`ifndef SYNTH
   a_kept_over_thr: assert property (@(posedge clock) disable iff (reset)
      s1_fire && s1_pos_ff.emit && s1_pos_ff.interior && kept_in != '0
      |-> CMP_W'(kept_in) >= CMP_W'(thr_ff))
      else $error("interior pixel kept below threshold");

   a_s1_held: assert property (@(posedge clock) disable iff (reset)
      s1_valid_ff && !s1_fire |=> s1_valid_ff && $stable(s1_slot_ff))
      else $error("stage 1 pixel dropped while stalled");

   a_out_source: assert property (@(posedge clock) disable iff (reset)
      $rose(out_valid_ff) |-> $past(s1_valid_ff && s1_pos_ff.emit))
      else $error("result appeared without a pixel that emits");

   a_fend_column: assert property (@(posedge clock) disable iff (reset)
      out_valid_ff && out_fend_ff |-> out_col_ff != '0)
      else $error("frame end reported at column zero");
`endif

endmodule

`default_nettype wire

/* rtl/nms_ram.sv */
`default_nettype none

module nms_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 2048,
   localparam int ADDR_W = $clog2(DEPTH)
) (
   input  wire logic              clock,
   input  wire logic              wr_en,
   input  wire logic [ADDR_W-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]  wr_data,
   input  wire logic              rd_en,
   input  wire logic [ADDR_W-1:0] rd_addr,
   output logic      [WIDTH-1:0]  rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data <= mem[rd_addr];
      end
   end

endmodule

`default_nettype wire

/* rtl/nms_pos.sv */
`default_nettype none

module nms_pos
   import nms_pkg::*;
#(
   parameter int MAX_WIDTH = 2048,
   localparam int ADDR_W = $clog2(MAX_WIDTH)
) (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire logic                 advance,
   input  wire logic [DIM_CFG_W-1:0] image_width,
   input  wire logic [DIM_CFG_W-1:0] image_height,
   output pos_info_type              pos,
   output logic      [ADDR_W-1:0]    slot
);

   localparam int CW = $clog2(MAX_WIDTH + 1);
   localparam int DW = (CW > DIM_CFG_W) ? CW : DIM_CFG_W;

   logic [CW-1:0]    col_ff, col_in;
   logic [ROW_W-1:0] row_ff, row_in;
   logic [DW-1:0]    w_cfg, w_lim, col_ext, col_inc, ec;
   logic [ROW_W-1:0] h_lim, er;
   logic             emit, interior, fend;

   always_comb begin
      w_cfg = DW'(image_width);
      priority if (w_cfg < DW'(3)) begin
         w_lim = DW'(3);
      end else if (w_cfg > DW'(MAX_WIDTH)) begin
         w_lim = DW'(MAX_WIDTH);
      end else begin
         w_lim = w_cfg;
      end

      priority if (ROW_W'(image_height) < ROW_W'(3)) begin
         h_lim = ROW_W'(3);
      end else if (ROW_W'(image_height) > ROW_W'(MAX_HEIGHT)) begin
         h_lim = ROW_W'(MAX_HEIGHT);
      end else begin
         h_lim = ROW_W'(image_height);
      end

      col_ext = DW'(col_ff);
      col_inc = col_ext + DW'(1);
      emit = (row_ff >= ROW_W'(1) && col_ff != '0) || row_ff >= ROW_W'(2);

      if (col_ff == '0) begin
         er = row_ff - ROW_W'(2);
         ec = w_lim - DW'(1);
      end else begin
         er = row_ff - ROW_W'(1);
         ec = col_ext - DW'(1);
      end

      interior = er != '0 && er < h_lim - ROW_W'(1) && ec != '0 && ec < w_lim - DW'(1);
      fend     = er >= h_lim - ROW_W'(1) && ec >= w_lim - DW'(1);

      col_in = col_ff;
      row_in = row_ff;
      if (advance) begin
         priority if (emit && fend) begin
            col_in = '0;
            row_in = '0;
         end else if (col_inc >= w_lim) begin
            col_in = '0;
            row_in = row_ff + ROW_W'(1);
         end else begin
            col_in = CW'(col_inc);
         end
      end

      pos.emit      = emit;
      pos.interior  = interior;
      pos.frame_end = fend;
      pos.row       = POS_W'(er);
      pos.column    = POS_W'(ec);
      slot          = col_ff[ADDR_W-1:0];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         col_ff <= '0;
         row_ff <= '0;
      end else begin
         col_ff <= col_in;
         row_ff <= row_in;
      end
   end

endmodule

`default_nettype wire

/* sim/tb_top.sv */
`timescale 1ns / 1ps

module tb_top;
   import nms_pkg::*;

   localparam int PIXEL_W        = 16;
   localparam int LINE_DEPTH     = 2048;
   localparam int SETTLE_CYCLES  = 8;
   localparam int WATCHDOG_LIMIT = 4000;
   localparam int PHASE_ITEMS    = 90;
   localparam int SHORT_RUN      = 24;
   localparam int TALL_RUN       = 30;

   localparam logic [CSR_IDX_W-1:0] CSR_SPARE = CSR_IDX_W'(3);

   typedef struct packed {
      logic [PIXEL_W-1:0] kept_value;
      logic [POS_W-1:0]   row;
      logic [POS_W-1:0]   column;
      logic               frame_end;
   } nms_pixel_type;

   typedef struct packed {
      logic [PIXEL_W-1:0] response;
      logic               padding;
      logic               typed;
      logic [PIXEL_W-1:0] kept;
      logic [POS_W-1:0]   out_row;
      logic [POS_W-1:0]   out_col;
      logic               last;
   } stim_row_type;

   typedef enum int {MIX_FULL, MIX_TIES, MIX_NEAR_THR} value_mix_type;

   // two 3x3 frames at threshold 1.0; untyped rows with a result come from the predictor
   localparam stim_row_type DIRECTED_ROWS [26] = '{
      '{16'd0,      1'b0, 1'b0, 16'd0,     11'd0, 11'd0, 1'b0},
      '{16'd65535,  1'b0, 1'b0, 16'd0,     11'd0, 11'd0, 1'b0},
      '{16'd5,      1'b0, 1'b0, 16'd0,     11'd0, 11'd0, 1'b0},
      '{16'd7,      1'b0, 1'b0, 16'd0,     11'd0, 11'd0, 1'b0},
      '{16'd65535,  1'b0, 1'b1, 16'd0,     11'd0, 11'd0, 1'b0},
      '{16'd256,    1'b0, 1'b1, 16'd65535, 11'd0, 11'd1, 1'b0},
      '{16'hFFFF,   1'b1, 1'b1, 16'd5,     11'd0, 11'd2, 1'b0},
      '{16'd9,      1'b0, 1'b1, 16'd7,     11'd1, 11'd0, 1'b0},
      '{16'd65535,  1'b0, 1'b1, 16'd65535, 11'd1, 11'd1, 1'b0},
      '{16'd0,      1'b1, 1'b1, 16'd256,   11'd1, 11'd2, 1'b0},
      '{16'd0,      1'b1, 1'b1, 16'd0,     11'd2, 11'd0, 1'b0},
      '{16'd1234,   1'b0, 1'b1, 16'd9,     11'd2, 11'd1, 1'b0},
      '{16'd0,      1'b1, 1'b1, 16'd65535, 11'd2, 11'd2, 1'b1},
      '{16'd1,      1'b0, 1'b0, 16'd0,     11'd0, 11'd0, 1'b0},
      '{16'd2,      1'b0, 1'b0, 16'd0,     11'd0, 11'd0, 1'b0},
      '{16'd3,      1'b0, 1'b0, 16'd0,     11'd0, 11'd0, 1'b0},
      '{16'd4,      1'b0, 1'b0, 16'd0,     11'd0, 11'd0, 1'b0},
      '{16'd256,    1'b0, 1'b1, 16'd1,     11'd0, 11'd0, 1'b0},
      '{16'd257,    1'b0, 1'b1, 16'd2,     11'd0, 11'd1, 1'b0},
      '{16'd5,      1'b0, 1'b1, 16'd3,     11'd0, 11'd2, 1'b0},
      '{16'd6,      1'b0, 1'b1, 16'd4,     11'd1, 11'd0, 1'b0},
      '{16'd0,      1'b0, 1'b0, 16'd0,     11'd0, 11'd0, 1'b0},
      '{16'hA5A5,   1'b1, 1'b1, 16'd257,   11'd1, 11'd2, 1'b0},
      '{16'd0,      1'b1, 1'b1, 16'd5,     11'd2, 11'd0, 1'b0},
      '{16'hFFFF,   1'b1, 1'b1, 16'd6,     11'd2, 11'd1, 1'b0},
      '{16'd0,      1'b1, 1'b1, 16'd0,     11'd2, 11'd2, 1'b1}
   };

   logic clock = 1'b0;
   logic reset;
   logic                  csr_we;
   logic [CSR_IDX_W-1:0]  csr_index;
   logic [CSR_DATA_W-1:0] csr_wdata;

   nms_req_if #(.PIXEL_BITS(PIXEL_W)) req_if ();
   nms_rsp_if #(.PIXEL_BITS(PIXEL_W)) rsp_if ();

   window_nonmax_suppress_threshold #(
      .MAX_WIDTH (LINE_DEPTH),
      .PIXEL_BITS(PIXEL_W)
   ) u_top (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_if.sink),
      .rsp_chan (rsp_if.source),
      .csr_we   (csr_we),
      .csr_index(csr_index),
      .csr_wdata(csr_wdata)
   );

   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   // predictor state
   logic [PIXEL_W-1:0]   pred_upper [LINE_DEPTH];
   logic [PIXEL_W-1:0]   pred_middle [LINE_DEPTH];
   logic [PIXEL_W-1:0]   pred_win [3][3];
   int unsigned          pred_row;
   int unsigned          pred_col;
   logic [DIM_CFG_W-1:0] cfg_width;
   logic [DIM_CFG_W-1:0] cfg_height;
   logic [THR_W-1:0]     cfg_min_resp;

   nms_pixel_type  pending_pixels [$];
   int unsigned    mismatch_count;
   int unsigned    items_sent;
   int unsigned    quiet_cycles;
   int             send_idle_pct;
   int             recv_stall_pct;
   nms_pixel_type  got_pixel;
   nms_pixel_type  want_pixel;

   function automatic int unsigned clamped_dim(input logic [DIM_CFG_W-1:0] raw,
                                               input int unsigned hi);
      if (raw < 3) return 3;
      if (raw > hi) return hi;
      return raw;
   endfunction

   task automatic predict_suppression(input logic [PIXEL_W-1:0] resp, input logic pad,
                                      output bit has_out, output nms_pixel_type px);
      int unsigned w, h, ir, ic, er, ec, slot;
      logic [PIXEL_W-1:0] x, ctr;
      bit keep;
      w = clamped_dim(cfg_width, LINE_DEPTH);
      h = clamped_dim(cfg_height, MAX_HEIGHT);
      x = pad ? '0 : resp;
      ir = pred_row;
      ic = pred_col;
      slot = ic % LINE_DEPTH;
      for (int r = 0; r < 3; r++) begin
         pred_win[r][0] = pred_win[r][1];
         pred_win[r][1] = pred_win[r][2];
      end
      pred_win[0][2] = pred_upper[slot];
      pred_win[1][2] = pred_middle[slot];
      pred_win[2][2] = x;
      pred_upper[slot] = pred_middle[slot];
      pred_middle[slot] = x;
      if (ic + 1 >= w) begin
         pred_col = 0;
         pred_row = ir + 1;
      end else begin
         pred_col = ic + 1;
      end
      has_out = 1'b0;
      px = '0;
      if ((ir >= 1 && ic >= 1) || ir >= 2) begin
         if (ic == 0) begin
            er = ir - 2;
            ec = w - 1;
         end else begin
            er = ir - 1;
            ec = ic - 1;
         end
         ctr = pred_win[1][1];
         px.kept_value = ctr;
         if (er != 0 && er < h - 1 && ec != 0 && ec < w - 1) begin
            keep = (ctr >= cfg_min_resp);
            for (int a = 0; a < 3; a++)
               for (int b = 0; b < 3; b++)
                  if (pred_win[a][b] > ctr) keep = 1'b0;
            if (!keep) px.kept_value = '0;
         end
         px.row = POS_W'(er);
         px.column = POS_W'(ec);
         px.frame_end = (er >= h - 1 && ec >= w - 1);
         if (px.frame_end) begin
            pred_row = 0;
            pred_col = 0;
         end
         has_out = 1'b1;
      end
   endtask

   function automatic logic [THR_W-1:0] pick_threshold();
      case ($urandom_range(3))
         0: return '0;
         1: return '1;
         2: return THR_W'($urandom_range(8));
         default: return THR_W'($urandom);
      endcase
   endfunction

   function automatic logic [PIXEL_W-1:0] pick_response(input value_mix_type mix);
      int unsigned lo, hi;
      lo = (cfg_min_resp > 3) ? cfg_min_resp - 3 : 0;
      hi = (cfg_min_resp > 65532) ? 65535 : cfg_min_resp + 3;
      case (mix)
         MIX_TIES:     return PIXEL_W'($urandom_range(7));
         MIX_NEAR_THR: return PIXEL_W'($urandom_range(hi, lo));
         default:      return PIXEL_W'($urandom);
      endcase
   endfunction

   task automatic send_pixel(input logic [PIXEL_W-1:0] resp, input logic pad,
                             input bit typed, input nms_pixel_type typed_px,
                             output bit ended);
      bit has_out;
      nms_pixel_type px;
      while ($urandom_range(99) < send_idle_pct) begin
         req_if.valid <= 1'b0;
         @(posedge clock);
      end
      predict_suppression(resp, pad, has_out, px);
      if (typed) pending_pixels.insert(pending_pixels.size(), typed_px);
      else if (has_out) pending_pixels.insert(pending_pixels.size(), px);
      ended = has_out && px.frame_end;
      req_if.valid    <= 1'b1;
      req_if.response <= resp;
      req_if.padding  <= pad;
      do @(posedge clock); while (!req_if.ready);
      items_sent++;
   endtask

   task automatic drain_results();
      req_if.valid <= 1'b0;
      while (pending_pixels.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic load_settings(input logic [DIM_CFG_W-1:0] width_raw,
                                input logic [DIM_CFG_W-1:0] height_raw,
                                input logic [THR_W-1:0] thr);
      csr_we    <= 1'b1;
      csr_index <= CSR_IMAGE_WIDTH;
      csr_wdata <= {4'($urandom), width_raw};
      @(posedge clock);
      csr_index <= CSR_IMAGE_HEIGHT;
      csr_wdata <= {4'($urandom), height_raw};
      @(posedge clock);
      csr_index <= CSR_MIN_RESPONSE;
      csr_wdata <= thr;
      @(posedge clock);
      if ($urandom_range(3) == 0) begin
         csr_index <= CSR_SPARE;
         csr_wdata <= CSR_DATA_W'($urandom);
         @(posedge clock);
      end
      csr_we <= 1'b0;
      cfg_width    = width_raw;
      cfg_height   = height_raw;
      cfg_min_resp = thr;
   endtask

   // mostly real pixels until the predictor's row passes the last row, then mostly padding
   task automatic run_frame(input value_mix_type mix, input int stop_after);
      int count;
      bit ended;
      logic [PIXEL_W-1:0] val;
      logic pad;
      count = 0;
      ended = 1'b0;
      while (!ended && (stop_after == 0 || count < stop_after)) begin
         if (pred_row < clamped_dim(cfg_height, MAX_HEIGHT)) begin
            pad = ($urandom_range(19) == 0);
            val = pick_response(mix);
         end else begin
            pad = ($urandom_range(9) != 0);
            val = PIXEL_W'($urandom);
         end
         send_pixel(val, pad, 1'b0, '0, ended);
         count++;
      end
   endtask

   task automatic check_field(input string name, input logic [PIXEL_W-1:0] want,
                              input logic [PIXEL_W-1:0] got);
      if (got !== want) begin
         mismatch_count++;
         $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
      end
   endtask

   always @(posedge clock) begin
      if (!reset && rsp_if.valid && rsp_if.ready) begin
         got_pixel = '{rsp_if.kept_value, rsp_if.row, rsp_if.column, rsp_if.frame_end};
         if (pending_pixels.size() == 0) begin
            mismatch_count++;
            $display("%0t: unexpected transfer, expected none, actual row %0d col %0d value %0d",
                     $time, got_pixel.row, got_pixel.column, got_pixel.kept_value);
         end else begin
            want_pixel = pending_pixels.pop_front();
            check_field("kept_value", want_pixel.kept_value, got_pixel.kept_value);
            check_field("row", PIXEL_W'(want_pixel.row), PIXEL_W'(got_pixel.row));
            check_field("column", PIXEL_W'(want_pixel.column), PIXEL_W'(got_pixel.column));
            check_field("frame_end", PIXEL_W'(want_pixel.frame_end),
                        PIXEL_W'(got_pixel.frame_end));
         end
      end
   end

   always @(posedge clock) begin
      rsp_if.ready <= ($urandom_range(99) >= recv_stall_pct);
   end

   always @(posedge clock) begin
      if (reset || (req_if.valid && req_if.ready) || (rsp_if.valid && rsp_if.ready))
         quiet_cycles <= 0;
      else
         quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= WATCHDOG_LIMIT) begin
         $display("%0t: watchdog expired with %0d transfers pending", $time,
                  pending_pixels.size());
         $display("Test completed with failures");
         $finish;
      end
   end

   initial begin
      logic [DIM_CFG_W-1:0] w_raw;
      logic [DIM_CFG_W-1:0] h_raw;
      value_mix_type mix;
      nms_pixel_type row_want;
      int unsigned phase_start;
      bit ended;

      reset           <= 1'b1;
      req_if.valid    <= 1'b0;
      req_if.response <= '0;
      req_if.padding  <= 1'b0;
      csr_we          <= 1'b0;
      csr_index       <= CSR_IMAGE_WIDTH;
      csr_wdata       <= '0;
      mismatch_count  = 0;
      items_sent      = 0;
      send_idle_pct   = 0;
      recv_stall_pct  = 0;
      cfg_width       = IMAGE_WIDTH_RESET;
      cfg_height      = IMAGE_HEIGHT_RESET;
      cfg_min_resp    = MIN_RESPONSE_RESET;
      pred_row        = 0;
      pred_col        = 0;
      for (int i = 0; i < LINE_DEPTH; i++) begin
         pred_upper[i]  = '0;
         pred_middle[i] = '0;
      end
      for (int r = 0; r < 3; r++)
         for (int c = 0; c < 3; c++)
            pred_win[r][c] = '0;
      repeat (5) @(posedge clock);
      reset <= 1'b0;

      // reset values: part of a default-width row, then shrink to 3x3 mid-frame
      run_frame(MIX_NEAR_THR, SHORT_RUN);
      drain_results();
      load_settings(DIM_CFG_W'(3), DIM_CFG_W'(3), MIN_RESPONSE_RESET);
      run_frame(MIX_NEAR_THR, 0);
      drain_results();

      load_settings(DIM_CFG_W'(3), DIM_CFG_W'(3), THR_W'(256));
      foreach (DIRECTED_ROWS[i]) begin
         row_want = '{DIRECTED_ROWS[i].kept, DIRECTED_ROWS[i].out_row,
                      DIRECTED_ROWS[i].out_col, DIRECTED_ROWS[i].last};
         send_pixel(DIRECTED_ROWS[i].response, DIRECTED_ROWS[i].padding,
                    DIRECTED_ROWS[i].typed, row_want, ended);
      end
      drain_results();

      // clamped extremes: widest line, tallest frame, each cut short
      load_settings('1, DIM_CFG_W'(1), '0);
      run_frame(MIX_TIES, SHORT_RUN);
      drain_results();
      load_settings('0, '1, '1);
      run_frame(MIX_NEAR_THR, TALL_RUN);

      for (int phase = 0; phase < 4; phase++) begin
         case (phase)
            0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
            1: begin send_idle_pct = 63; recv_stall_pct = 0;  end
            2: begin send_idle_pct = 0;  recv_stall_pct = 63; end
            default: begin send_idle_pct = 37; recv_stall_pct = 37; end
         endcase
         phase_start = items_sent;
         while (items_sent - phase_start < PHASE_ITEMS) begin
            w_raw = ($urandom_range(9) == 0) ? DIM_CFG_W'($urandom_range(2))
                                             : DIM_CFG_W'($urandom_range(10, 3));
            h_raw = ($urandom_range(9) == 0) ? DIM_CFG_W'($urandom_range(2))
                                             : DIM_CFG_W'($urandom_range(8, 3));
            mix = value_mix_type'($urandom_range(2));
            drain_results();
            load_settings(w_raw, h_raw, pick_threshold());
            if ($urandom_range(3) == 0) begin
               // threshold change in the middle of a frame
               run_frame(mix, $urandom_range(clamped_dim(w_raw, LINE_DEPTH) *
                                             clamped_dim(h_raw, MAX_HEIGHT) - 1, 1));
               drain_results();
               load_settings(w_raw, h_raw, pick_threshold());
            end
            run_frame(mix, 0);
         end
      end

      drain_results();
      if (mismatch_count == 0)
         $display("Test completed successfully");
      else
         $display("Test completed with failures");
      $finish;
   end

endmodule

/* sim.f */
rtl/nms_pkg.sv
rtl/nms_stream_if.sv
rtl/nms_ram.sv
rtl/nms_pos.sv
rtl/window_nonmax_suppress_threshold.sv
sim/tb_top.sv
